FILE: hw/rtl/cpg_pkg.sv
// Shared widths, request codes and the step word type for the circle point generator.
// No dependencies; used by every module under hw/rtl.
`default_nettype none

package cpg_pkg;

	localparam int RADIUS_BITS = 10;
	localparam int COORD_BITS  = 12;
	localparam int OFF_BITS    = RADIUS_BITS + 1;
	localparam int DEC_BITS    = RADIUS_BITS + 4;
	localparam int PT_BITS     = COORD_BITS + 1;
	localparam int ATTR_BITS   = 8;
	localparam int PTS_PER_STEP = 8;
	localparam int IDX_BITS    = $clog2(PTS_PER_STEP);

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	localparam int DEC_INIT    = 3;
	localparam int DEC_GROW_A  = 6;
	localparam int DEC_GROW_AB = 10;

	typedef logic [IDX_BITS-1:0] idx_t;
	localparam idx_t LAST_IDX = idx_t'(PTS_PER_STEP - 1);

	typedef struct packed {
		logic signed [OFF_BITS-1:0]   a;
		logic signed [OFF_BITS-1:0]   b;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [ATTR_BITS-1:0]         glyph;
		logic [ATTR_BITS-1:0]         colour;
		logic                         done;
	} step_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cpg_ctl.sv
// Circle state: center, octant offsets, decision value and attributes.
// Loads on start, advances one octant step per step word taken while busy. Depends on cpg_pkg.
`default_nettype none

module cpg_ctl (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic                                  advance,
	input  wire logic signed [cpg_pkg::COORD_BITS-1:0] center_x,
	input  wire logic signed [cpg_pkg::COORD_BITS-1:0] center_y,
	input  wire logic [cpg_pkg::RADIUS_BITS-1:0]       radius,
	input  wire logic [cpg_pkg::ATTR_BITS-1:0]         glyph,
	input  wire logic [cpg_pkg::ATTR_BITS-1:0]         colour,
	output logic                                       busy,
	output cpg_pkg::step_t                             step
);

	logic                                  busy_q;
	logic signed [cpg_pkg::COORD_BITS-1:0] mid_x_q;
	logic signed [cpg_pkg::COORD_BITS-1:0] mid_y_q;
	logic signed [cpg_pkg::OFF_BITS-1:0]   off_a_q;
	logic signed [cpg_pkg::OFF_BITS-1:0]   off_b_q;
	logic signed [cpg_pkg::DEC_BITS-1:0]   dec_q;
	logic [cpg_pkg::ATTR_BITS-1:0]         glyph_q;
	logic [cpg_pkg::ATTR_BITS-1:0]         colour_q;

	logic signed [cpg_pkg::OFF_BITS-1:0]   na;
	logic signed [cpg_pkg::OFF_BITS-1:0]   nb;
	logic signed [cpg_pkg::DEC_BITS-1:0]   nd;
	logic signed [cpg_pkg::DEC_BITS-1:0]   a_ext;
	logic signed [cpg_pkg::DEC_BITS-1:0]   b_ext;
	logic signed [cpg_pkg::DEC_BITS-1:0]   d_init;
	logic                                  done;

	always_comb begin
		a_ext = cpg_pkg::DEC_BITS'(off_a_q);
		b_ext = cpg_pkg::DEC_BITS'(off_b_q);
		na    = off_a_q + cpg_pkg::OFF_BITS'(1);
		if (dec_q[cpg_pkg::DEC_BITS-1]) begin
			nd = dec_q + (a_ext <<< 2) + cpg_pkg::DEC_BITS'(cpg_pkg::DEC_GROW_A);
			nb = off_b_q;
		end else begin
			nd = dec_q + ((a_ext - b_ext) <<< 2) + cpg_pkg::DEC_BITS'(cpg_pkg::DEC_GROW_AB);
			nb = off_b_q - cpg_pkg::OFF_BITS'(1);
		end
		done   = (nb < na);
		d_init = cpg_pkg::DEC_BITS'(cpg_pkg::DEC_INIT)
			- (cpg_pkg::DEC_BITS'(radius) << 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			mid_x_q  <= '0;
			mid_y_q  <= '0;
			off_a_q  <= '0;
			off_b_q  <= '0;
			dec_q    <= '0;
			glyph_q  <= '0;
			colour_q <= '0;
		end else if (start) begin
			busy_q   <= (radius != '0);
			mid_x_q  <= center_x;
			mid_y_q  <= center_y;
			off_a_q  <= '0;
			off_b_q  <= cpg_pkg::OFF_BITS'(radius);
			dec_q    <= d_init;
			glyph_q  <= glyph;
			colour_q <= colour;
		end else if (advance) begin
			dec_q   <= nd;
			off_a_q <= na;
			off_b_q <= nb;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy        = busy_q;
	assign step.a      = off_a_q;
	assign step.b      = off_b_q;
	assign step.cx     = mid_x_q;
	assign step.cy     = mid_y_q;
	assign step.glyph  = glyph_q;
	assign step.colour = colour_q;
	assign step.done   = done;

endmodule

`default_nettype wire

FILE: hw/rtl/cpg_emit.sv
// Point emitter: holds one step word and sends its eight mirrored points through an
// output register, one per cycle while the output does not stall. Depends on cpg_pkg.
`default_nettype none

module cpg_emit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           load,
	input  wire cpg_pkg::step_t                 step_in,
	input  wire logic                           out_stall,
	output logic                                pend,
	output logic                                finishing,
	output logic                                out_valid,
	output logic signed [cpg_pkg::PT_BITS-1:0]  point_x,
	output logic signed [cpg_pkg::PT_BITS-1:0]  point_y,
	output logic [cpg_pkg::ATTR_BITS-1:0]       glyph_out,
	output logic [cpg_pkg::ATTR_BITS-1:0]       colour_out,
	output logic                                last_of_step,
	output logic                                circle_done
);

	cpg_pkg::step_t step_q;
	logic           step_v_q;
	cpg_pkg::idx_t  idx_q;
	logic           move;
	logic           last;

	logic signed [cpg_pkg::PT_BITS-1:0] a_w;
	logic signed [cpg_pkg::PT_BITS-1:0] b_w;
	logic signed [cpg_pkg::PT_BITS-1:0] dx;
	logic signed [cpg_pkg::PT_BITS-1:0] dy;
	logic signed [cpg_pkg::PT_BITS-1:0] px;
	logic signed [cpg_pkg::PT_BITS-1:0] py;

	logic                               out_valid_q;
	logic signed [cpg_pkg::PT_BITS-1:0] point_x_q;
	logic signed [cpg_pkg::PT_BITS-1:0] point_y_q;
	logic [cpg_pkg::ATTR_BITS-1:0]      glyph_q;
	logic [cpg_pkg::ATTR_BITS-1:0]      colour_q;
	logic                               last_q;
	logic                               done_q;

	assign move      = step_v_q && (!out_valid_q || !out_stall);
	assign last      = (idx_q == cpg_pkg::LAST_IDX);
	assign finishing = move && last;
	assign pend      = step_v_q;

	always_comb begin
		a_w = cpg_pkg::PT_BITS'(step_q.a);
		b_w = cpg_pkg::PT_BITS'(step_q.b);
		unique case (idx_q[1:0])
			2'd0: begin dx = -a_w; dy = b_w; end
			2'd1: begin dx = -b_w; dy = a_w; end
			2'd2: begin dx = b_w;  dy = a_w; end
			default: begin dx = a_w; dy = b_w; end
		endcase
		px = cpg_pkg::PT_BITS'(step_q.cx) + dx;
		if (idx_q[cpg_pkg::IDX_BITS-1]) begin
			py = cpg_pkg::PT_BITS'(step_q.cy) + dy;
		end else begin
			py = cpg_pkg::PT_BITS'(step_q.cy) - dy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_v_q <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			step_v_q <= 1'b1;
			idx_q    <= '0;
		end else if (move) begin
			idx_q <= idx_q + cpg_pkg::idx_t'(1);
			if (last) begin
				step_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			step_q <= step_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			point_x_q <= px;
			point_y_q <= py;
			glyph_q   <= step_q.glyph;
			colour_q  <= step_q.colour;
			last_q    <= last;
			done_q    <= last && step_q.done;
		end
	end

	assign out_valid    = out_valid_q;
	assign point_x      = point_x_q;
	assign point_y      = point_y_q;
	assign glyph_out    = glyph_q;
	assign colour_out   = colour_q;
	assign last_of_step = last_q;
	assign circle_done  = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/midpoint_circle_point_generator.sv
// Midpoint circle point generator. A start word loads center, radius, glyph and colour
// and gives no points. A step word gives the eight mirrored points of the current octant
// offset, one per cycle from the output register while the output does not stall; the
// next word is taken in the cycle the eighth point enters the output register, so a new
// word can be taken while earlier points still wait in the output register. Steps while
// idle are taken and give nothing.
// Depends on cpg_pkg, cpg_ctl and cpg_emit.
`default_nettype none

module midpoint_circle_point_generator (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  req_type,
	input  wire logic signed [cpg_pkg::COORD_BITS-1:0] center_x,
	input  wire logic signed [cpg_pkg::COORD_BITS-1:0] center_y,
	input  wire logic [cpg_pkg::RADIUS_BITS-1:0]       radius,
	input  wire logic [cpg_pkg::ATTR_BITS-1:0]         glyph,
	input  wire logic [cpg_pkg::ATTR_BITS-1:0]         colour,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [cpg_pkg::PT_BITS-1:0]         point_x,
	output logic signed [cpg_pkg::PT_BITS-1:0]         point_y,
	output logic [cpg_pkg::ATTR_BITS-1:0]              glyph_out,
	output logic [cpg_pkg::ATTR_BITS-1:0]              colour_out,
	output logic                                       last_of_step,
	output logic                                       circle_done
);

	logic           accept;
	logic           start;
	logic           advance;
	logic           busy;
	logic           pend;
	logic           finishing;
	cpg_pkg::step_t step;

	assign in_stall = pend && !finishing;
	assign accept   = in_valid && !in_stall;
	assign start    = accept && (req_type == cpg_pkg::REQ_START);
	assign advance  = accept && (req_type == cpg_pkg::REQ_STEP) && busy;

	cpg_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.advance  (advance),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.glyph    (glyph),
		.colour   (colour),
		.busy     (busy),
		.step     (step)
	);

	cpg_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.step_in      (step),
		.out_stall    (out_stall),
		.pend         (pend),
		.finishing    (finishing),
		.out_valid    (out_valid),
		.point_x      (point_x),
		.point_y      (point_y),
		.glyph_out    (glyph_out),
		.colour_out   (colour_out),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

`ifndef ASSERT_OFF
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && circle_done |-> last_of_step)
		else $error("circle_done without last_of_step");

	a_stall_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> pend)
		else $error("input stalled with no step pending");

	a_step_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> pend && !out_valid || pend)
		else $error("accepted step did not load the emitter");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step.done |=> !busy)
		else $error("busy held after final step");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for midpoint_circle_point_generator: drives start and step words and
// predicts every plotted point, checking each one field by field in arrival order.
// Depends on cpg_pkg and the midpoint_circle_point_generator RTL.

module tb_top;

	localparam int QUIET_LIMIT = 1000;

	typedef struct {
		logic signed [cpg_pkg::PT_BITS-1:0] x;
		logic signed [cpg_pkg::PT_BITS-1:0] y;
		logic [cpg_pkg::ATTR_BITS-1:0]      glyph;
		logic [cpg_pkg::ATTR_BITS-1:0]      colour;
		logic                               last;
		logic                               done;
	} point_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   in_valid = 1'b0;
	logic                                   in_stall;
	logic                                   req_type = cpg_pkg::REQ_START;
	logic signed [cpg_pkg::COORD_BITS-1:0]  center_x = '0;
	logic signed [cpg_pkg::COORD_BITS-1:0]  center_y = '0;
	logic [cpg_pkg::RADIUS_BITS-1:0]        radius = '0;
	logic [cpg_pkg::ATTR_BITS-1:0]          glyph = '0;
	logic [cpg_pkg::ATTR_BITS-1:0]          colour = '0;
	logic                                   out_valid;
	logic                                   out_stall = 1'b0;
	logic signed [cpg_pkg::PT_BITS-1:0]     point_x;
	logic signed [cpg_pkg::PT_BITS-1:0]     point_y;
	logic [cpg_pkg::ATTR_BITS-1:0]          glyph_out;
	logic [cpg_pkg::ATTR_BITS-1:0]          colour_out;
	logic                                   last_of_step;
	logic                                   circle_done;

	logic                                   circ_busy = 1'b0;
	logic signed [cpg_pkg::COORD_BITS-1:0]  circ_cx = '0;
	logic signed [cpg_pkg::COORD_BITS-1:0]  circ_cy = '0;
	logic signed [cpg_pkg::OFF_BITS-1:0]    circ_a = '0;
	logic signed [cpg_pkg::OFF_BITS-1:0]    circ_b = '0;
	logic signed [cpg_pkg::DEC_BITS-1:0]    circ_d = '0;
	logic [cpg_pkg::ATTR_BITS-1:0]          circ_glyph = '0;
	logic [cpg_pkg::ATTR_BITS-1:0]          circ_colour = '0;

	point_t pending_points[$];
	point_t want;
	bit     idle_en = 1'b1;
	int     stall_left = 0;
	int     quiet_cycles = 0;
	int     fails = 0;
	int     words_sent = 0;
	int     starts_sent = 0;
	int     points_seen = 0;
	int     circles_seen = 0;

	midpoint_circle_point_generator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.center_x     (center_x),
		.center_y     (center_y),
		.radius       (radius),
		.glyph        (glyph),
		.colour       (colour),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.glyph_out    (glyph_out),
		.colour_out   (colour_out),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

	always #10 clk = ~clk;

	function automatic void plot_step(input logic rt,
			input logic signed [cpg_pkg::COORD_BITS-1:0] cx,
			input logic signed [cpg_pkg::COORD_BITS-1:0] cy,
			input logic [cpg_pkg::RADIUS_BITS-1:0] r,
			input logic [cpg_pkg::ATTR_BITS-1:0] g, input logic [cpg_pkg::ATTR_BITS-1:0] c);
		int     ia;
		int     ib;
		int     dx[cpg_pkg::PTS_PER_STEP];
		int     dy[cpg_pkg::PTS_PER_STEP];
		logic   done;
		point_t p;
		if (rt == cpg_pkg::REQ_START) begin
			circ_cx = cx;
			circ_cy = cy;
			circ_glyph = g;
			circ_colour = c;
			circ_a = '0;
			circ_b = {1'b0, r};
			circ_d = cpg_pkg::DEC_BITS'(cpg_pkg::DEC_INIT - 2 * int'(r));
			circ_busy = (r != '0);
			return;
		end
		if (!circ_busy || circ_b < circ_a)
			return;
		ia = int'(circ_a);
		ib = int'(circ_b);
		if (circ_d < 0) begin
			circ_d = cpg_pkg::DEC_BITS'(int'(circ_d) + 4 * ia + cpg_pkg::DEC_GROW_A);
		end else begin
			circ_d = cpg_pkg::DEC_BITS'(int'(circ_d) + 4 * (ia - ib) + cpg_pkg::DEC_GROW_AB);
			circ_b = cpg_pkg::OFF_BITS'(ib - 1);
		end
		circ_a = cpg_pkg::OFF_BITS'(ia + 1);
		done = (circ_b < circ_a);
		if (done)
			circ_busy = 1'b0;
		dx = '{-ia, -ib, ib, ia, -ia, -ib, ib, ia};
		dy = '{-ib, -ia, -ia, -ib, ib, ia, ia, ib};
		for (int k = 0; k < cpg_pkg::PTS_PER_STEP; k++) begin
			p.x = cpg_pkg::PT_BITS'(int'(circ_cx) + dx[k]);
			p.y = cpg_pkg::PT_BITS'(int'(circ_cy) + dy[k]);
			p.glyph = circ_glyph;
			p.colour = circ_colour;
			p.last = (k == cpg_pkg::PTS_PER_STEP - 1);
			p.done = p.last && done;
			pending_points = {pending_points, p};
		end
	endfunction

	function automatic void check_field(input string name, input logic signed [15:0] exp_v,
			input logic signed [15:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fails++;
		end
	endfunction

	task automatic send_word(input logic rt,
			input logic signed [cpg_pkg::COORD_BITS-1:0] cx,
			input logic signed [cpg_pkg::COORD_BITS-1:0] cy,
			input logic [cpg_pkg::RADIUS_BITS-1:0] r,
			input logic [cpg_pkg::ATTR_BITS-1:0] g, input logic [cpg_pkg::ATTR_BITS-1:0] c);
		logic held;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		center_x <= cx;
		center_y <= cy;
		radius <= r;
		glyph <= g;
		colour <= c;
		do begin
			@(negedge clk);
			held = in_stall;
			@(posedge clk);
		end while (held);
		plot_step(rt, cx, cy, r, g, c);
		words_sent++;
		if (rt == cpg_pkg::REQ_START)
			starts_sent++;
	endtask

	task automatic send_step();
		send_word(cpg_pkg::REQ_STEP, cpg_pkg::COORD_BITS'($urandom),
			cpg_pkg::COORD_BITS'($urandom), cpg_pkg::RADIUS_BITS'($urandom),
			cpg_pkg::ATTR_BITS'($urandom), cpg_pkg::ATTR_BITS'($urandom));
	endtask

	task automatic send_start(input logic [cpg_pkg::RADIUS_BITS-1:0] r);
		send_word(cpg_pkg::REQ_START, cpg_pkg::COORD_BITS'($urandom),
			cpg_pkg::COORD_BITS'($urandom), r,
			cpg_pkg::ATTR_BITS'($urandom), cpg_pkg::ATTR_BITS'($urandom));
	endtask

	task automatic finish_circle();
		while (circ_busy)
			send_step();
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_points.size() != 0);
	endtask

	task automatic test_idle_steps();
		send_step();
		send_word(cpg_pkg::REQ_START, 12'sd100, -12'sd100, '0, 8'h5A, 8'hA5);
		send_step();
	endtask

	task automatic test_extremes();
		send_word(cpg_pkg::REQ_START, 12'sd2047, -12'sd2048, 10'd1023, 8'hFF, 8'h00);
		repeat (3) send_step();
		send_word(cpg_pkg::REQ_START, -12'sd2048, 12'sd2047, 10'd1, 8'h00, 8'hFF);
		finish_circle();
		send_step();
	endtask

	task automatic test_restart();
		send_word(cpg_pkg::REQ_START, 12'sd0, 12'sd0, 10'd5, 8'h11, 8'h22);
		repeat (2) send_step();
		send_word(cpg_pkg::REQ_START, -12'sd7, 12'sd9, 10'd3, 8'h33, 8'h44);
		finish_circle();
		send_word(cpg_pkg::REQ_START, 12'sd1, -12'sd1, 10'd2, 8'h80, 8'h01);
		finish_circle();
	endtask

	task automatic test_drain_pause();
		send_start(cpg_pkg::RADIUS_BITS'($urandom_range(4, 9)));
		repeat (2) send_step();
		wait_drained();
		finish_circle();
	endtask

	task automatic test_random_circles(input int n_words);
		int target;
		int pick;
		int steps;
		target = words_sent + n_words;
		while (words_sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				repeat ($urandom_range(1, 2)) send_step();
			end else if (pick == 1) begin
				send_start(cpg_pkg::RADIUS_BITS'($urandom));
				steps = $urandom_range(1, 5);
				repeat (steps) send_step();
			end else begin
				send_start(cpg_pkg::RADIUS_BITS'($urandom_range(0, 12)));
				if ($urandom_range(0, 7) == 0) begin
					steps = $urandom_range(1, 3);
					repeat (steps) send_step();
				end else begin
					finish_circle();
					if ($urandom_range(0, 2) == 0)
						send_step();
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			points_seen++;
			if (pending_points.size() == 0) begin
				$error("point (%0d, %0d) arrived with no step pending", point_x, point_y);
				fails++;
			end else begin
				want = pending_points.pop_front();
				check_field("point_x", 16'(want.x), 16'(point_x));
				check_field("point_y", 16'(want.y), 16'(point_y));
				check_field("glyph_out", 16'(want.glyph), 16'(glyph_out));
				check_field("colour_out", 16'(want.colour), 16'(colour_out));
				check_field("last_of_step", 16'(want.last), 16'(last_of_step));
				check_field("circle_done", 16'(want.done), 16'(circle_done));
				if (want.done)
					circles_seen++;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_steps();
		test_extremes();
		test_restart();
		test_random_circles(45);
		test_drain_pause();
		test_random_circles(25);
		wait_drained();
		idle_en = 1'b0;
		test_random_circles(20);
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d words (%0d starts), %0d points, %0d circles run to completion",
			words_sent, starts_sent, points_seen, circles_seen);
		$display("Included idle steps, zero radius, restarts mid-circle and extreme centers");
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
